/* rtl/assert_macros.svh */
// Assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active
`define CRSS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("crss assertion failed");

// Clocked assertion that is also checked during reset
`define CRSS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("crss assertion failed");

`endif

/* rtl/crss_pkg.sv */
// Package with sizes, codes and shared types of the coil root-sum-of-squares core
`default_nettype none
package crss_pkg;

  localparam int MAX_PIXELS  = 4096;
  localparam int MAX_COILS   = 64;
  localparam int SAMPLE_BITS = 16;

  localparam int PIX_W  = $clog2(MAX_PIXELS);
  localparam int COIL_W = $clog2(MAX_COILS);
  localparam int PCNT_W = PIX_W + 1;
  localparam int CCNT_W = COIL_W + 1;
  localparam int CFG_W  = (PCNT_W > CCNT_W) ? PCNT_W : CCNT_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W  = 37;
  localparam int MAG_W  = 19;
  localparam int RAD_W  = 2 * MAG_W;
  localparam int REM_W  = MAG_W + 2;
  localparam int STEP_W = $clog2(MAG_W);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [0:0] REG_PIXEL_COUNT = 1'b0;
  localparam logic [0:0] REG_COIL_COUNT  = 1'b1;

  localparam logic [PCNT_W-1:0] PIXEL_COUNT_RST = PCNT_W'(MAX_PIXELS);
  localparam logic [CCNT_W-1:0] COIL_COUNT_RST  = CCNT_W'(1);

  typedef struct packed {
    logic [PIX_W-1:0] addr;
    logic [SQ_W-1:0]  square;
    logic             first;
    logic             emit;
    logic             last;
  } crss_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_ROOT,
    ST_OUT
  } crss_state_e;

endpackage
`default_nettype wire

/* rtl/crss_ram.sv */
// Generic single-port-write, registered-read RAM
`default_nettype none
module crss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/crss_front.sv */
// Front end: configuration, pixel and coil tracking, squaring of each sample
`default_nettype none
module crss_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [0:0]                           cfg_idx_i,
  input  logic [crss_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                 push,
  input  logic signed [crss_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                 full,
  output logic                                 q_push_o,
  output crss_pkg::crss_cmd_t                  q_cmd_o,
  input  logic                                 q_full_i
);
  import crss_pkg::*;

  logic [PCNT_W-1:0] pcnt_q;
  logic [CCNT_W-1:0] ccnt_q;
  logic [PIX_W-1:0]  pixel_q, pixel_d;
  logic [COIL_W-1:0] coil_q, coil_d;

  logic [PCNT_W-1:0] npix;
  logic [CCNT_W-1:0] ncoil;
  logic [PIX_W-1:0]  pos;
  logic              last_pix;
  logic              last_coil;
  logic              accept;
  logic signed [2*SAMPLE_BITS-1:0] prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= PIXEL_COUNT_RST;
      ccnt_q <= COIL_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PIXEL_COUNT: pcnt_q <= cfg_wdata_i[PCNT_W-1:0];
        REG_COIL_COUNT:  ccnt_q <= cfg_wdata_i[CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (pcnt_q == '0) npix = PCNT_W'(1);
    else if (pcnt_q > PCNT_W'(MAX_PIXELS)) npix = PCNT_W'(MAX_PIXELS);
    else npix = pcnt_q;

    priority if (ccnt_q == '0) ncoil = CCNT_W'(1);
    else if (ccnt_q > CCNT_W'(MAX_COILS)) ncoil = CCNT_W'(MAX_COILS);
    else ncoil = ccnt_q;

    if ({1'b0, pixel_q} >= npix) pos = PIX_W'(npix - PCNT_W'(1));
    else pos = pixel_q;

    last_pix  = ({1'b0, pos} + PCNT_W'(1)) >= npix;
    last_coil = ({1'b0, coil_q} + CCNT_W'(1)) >= ncoil;

    if (last_pix) begin
      pixel_d = '0;
      coil_d  = last_coil ? '0 : coil_q + COIL_W'(1);
    end else begin
      pixel_d = pos + PIX_W'(1);
      coil_d  = coil_q;
    end
  end

  assign accept = push && !q_full_i;
  assign full   = q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_q <= '0;
      coil_q  <= '0;
    end else if (accept) begin
      pixel_q <= pixel_d;
      coil_q  <= coil_d;
    end
  end

  assign prod = (2*SAMPLE_BITS)'(sample_i) * (2*SAMPLE_BITS)'(sample_i);

  assign q_push_o       = accept;
  assign q_cmd_o.addr   = pos;
  assign q_cmd_o.square = prod[SQ_W-1:0];
  assign q_cmd_o.first  = (coil_q == '0);
  assign q_cmd_o.emit   = last_coil;
  assign q_cmd_o.last   = last_pix;

endmodule
`default_nettype wire

/* rtl/crss_queue.sv */
// Short command queue between the front and back ends
`default_nettype none
module crss_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  crss_pkg::crss_cmd_t cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output crss_pkg::crss_cmd_t cmd_o,
  output logic                empty_o
);
  import crss_pkg::*;

  crss_cmd_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + QPTR_W'(1);
      if (do_pop)  rptr_q <= rptr_q + QPTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= cmd_i;
  end

endmodule
`default_nettype wire

/* rtl/crss_back.sv */
// Back end: accumulator read-modify-write, bit-serial square root, result register
`default_nettype none
module crss_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  crss_pkg::crss_cmd_t            q_cmd_i,
  output logic                           q_pop_o,
  output logic                           empty,
  input  logic                           pop,
  output logic [crss_pkg::MAG_W-1:0]     magnitude_o,
  output logic                           last_pixel_o
);
  import crss_pkg::*;

  crss_state_e       state_q, state_d;
  crss_cmd_t         cmd_q;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [MAG_W-1:0]  root_q, root_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic [MAG_W-1:0]  mag_q;
  logic              last_q;

  logic              load_out;
  logic              ram_we;
  logic [SUM_W-1:0]  ram_rdata;
  logic [SUM_W-1:0]  total;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;

  crss_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_PIXELS)
  ) u_sum_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cmd_q.addr),
    .wdata_i(total),
    .re_i   (q_pop_o),
    .raddr_i(q_cmd_i.addr),
    .rdata_o(ram_rdata)
  );

  assign total  = cmd_q.first ? SUM_W'(cmd_q.square) : ram_rdata + SUM_W'(cmd_q.square);
  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root_q, 2'b01});

  always_comb begin
    state_d     = state_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    step_d      = step_q;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !pop;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        ram_we = 1'b1;
        if (cmd_q.emit) begin
          rad_d   = RAD_W'(total);
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = ST_ROOT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ROOT: begin
        rad_d = rad_q << 2;
        if (rem_sh >= trial) begin
          rem_d  = REM_W'(rem_sh - trial);
          root_d = {root_q[MAG_W-2:0], 1'b1};
        end else begin
          rem_d  = REM_W'(rem_sh);
          root_d = {root_q[MAG_W-2:0], 1'b0};
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(MAG_W - 1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || pop) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cmd_q <= q_cmd_i;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    if (load_out) begin
      mag_q  <= root_q;
      last_q <= cmd_q.last;
    end
  end

  assign empty        = !out_valid_q;
  assign magnitude_o  = mag_q;
  assign last_pixel_o = last_q;

endmodule
`default_nettype wire

/* rtl/coil_root_sum_of_squares_core.sv */
// Top level of the coil root-sum-of-squares core
//
//   port group   direction  handshake        payload
//   samples      in         push / full      sample_i
//   results      out        empty / pop      magnitude_o, last_pixel_o
//   config       in         cfg_we_i         cfg_idx_i, cfg_wdata_i
//
// A sample that adds to the accumulator passes the back end in ST_IDLE, a
// registered read of the sum RAM, then in ST_ACC, the add and write back.
// A sample of the last coil then takes 19 steps of the one-bit-per-cycle
// square root in ST_ROOT; ST_OUT loads the result register when it is empty or popped.
// The front end keeps accepting up to 4 samples while the back end works.
// Reset clears positions and the queue and sets a full image of one coil; the sum RAM holds whatever it held.
`default_nettype none
module coil_root_sum_of_squares_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [0:0]                              cfg_idx_i,
  input  logic [crss_pkg::CFG_W-1:0]              cfg_wdata_i,
  input  logic                                    push,
  output logic                                    full,
  input  logic signed [crss_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                    empty,
  input  logic                                    pop,
  output logic [crss_pkg::MAG_W-1:0]              magnitude_o,
  output logic                                    last_pixel_o
);
  import crss_pkg::*;

  logic      fq_push;
  logic      fq_full;
  crss_cmd_t fq_cmd;
  logic      bq_pop;
  logic      bq_empty;
  crss_cmd_t bq_cmd;

  crss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .sample_i   (sample_i),
    .full       (full),
    .q_push_o   (fq_push),
    .q_cmd_o    (fq_cmd),
    .q_full_i   (fq_full)
  );

  crss_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fq_push),
    .cmd_i  (fq_cmd),
    .full_o (fq_full),
    .pop_i  (bq_pop),
    .cmd_o  (bq_cmd),
    .empty_o(bq_empty)
  );

  crss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (bq_empty),
    .q_cmd_i     (bq_cmd),
    .q_pop_o     (bq_pop),
    .empty       (empty),
    .pop         (pop),
    .magnitude_o (magnitude_o),
    .last_pixel_o(last_pixel_o)
  );

endmodule
`default_nettype wire

/* rtl/crss_checker.sv */
// Port-level checker for the coil root-sum-of-squares core, with its bind
`default_nettype none
`include "assert_macros.svh"
module crss_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    cfg_we_i,
  input logic [0:0]                              cfg_idx_i,
  input logic [crss_pkg::CFG_W-1:0]              cfg_wdata_i,
  input logic                                    push,
  input logic                                    full,
  input logic signed [crss_pkg::SAMPLE_BITS-1:0] sample_i,
  input logic                                    empty,
  input logic                                    pop,
  input logic [crss_pkg::MAG_W-1:0]              magnitude_o,
  input logic                                    last_pixel_o
);
  import crss_pkg::*;

  logic cfg_seen;
  assign cfg_seen = cfg_we_i || (cfg_idx_i != cfg_idx_i) || (cfg_wdata_i != cfg_wdata_i)
                    || (sample_i != sample_i);

  `CRSS_ASSERT(a_result_holds, !empty && !pop |=> !empty && $stable(magnitude_o) && $stable(last_pixel_o))
  `CRSS_ASSERT(a_mag_range, !empty |-> magnitude_o <= MAG_W'(1 << (MAG_W - 1)))
  `CRSS_ASSERT(a_empty_on_pop, $rose(empty) |-> $past(pop) || $past(cfg_seen && 1'b0))
  `CRSS_ASSERT(a_full_on_push, $rose(full) |-> $past(push))

endmodule

bind coil_root_sum_of_squares_core crss_checker u_crss_checker (.*);
`default_nettype wire

/* tb/coil_root_sum_of_squares_core_test.sv */
// Self-checking testbench for the coil root-sum-of-squares core
module coil_root_sum_of_squares_core_test;
  import crss_pkg::*;

  localparam int RANDOM_ITEMS   = 1350;
  localparam int ITEMS_PLANNED  = RANDOM_ITEMS + 25;
  localparam int DRAIN_CYCLES   = 150;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             last_pixel;
  } pixel_result_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [0:0]                    cfg_idx_i   = REG_PIXEL_COUNT;
  logic [CFG_W-1:0]              cfg_wdata_i = '0;
  logic                          push        = 1'b0;
  logic                          full;
  logic signed [SAMPLE_BITS-1:0] sample_i    = '0;
  logic                          empty;
  logic                          pop         = 1'b0;
  logic [MAG_W-1:0]              magnitude_o;
  logic                          last_pixel_o;

  coil_root_sum_of_squares_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .sample_i     (sample_i),
    .empty        (empty),
    .pop          (pop),
    .magnitude_o  (magnitude_o),
    .last_pixel_o (last_pixel_o)
  );

  always #4 clk_i = ~clk_i;

  logic signed [SAMPLE_BITS-1:0] samples_pending[$];
  pixel_result_t                 magnitudes_due[$];
  pixel_result_t                 due;

  logic [SUM_W-1:0]  pixel_sums    [MAX_PIXELS];
  bit                pixel_written [MAX_PIXELS];
  logic [PCNT_W-1:0] pixel_reg = PIXEL_COUNT_RST;
  logic [CCNT_W-1:0] coil_reg  = COIL_COUNT_RST;
  int unsigned       pixel_at  = 0;
  int unsigned       coil_at   = 0;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          n_queued      = 0;
  int          n_accepted    = 0;
  int          n_checked     = 0;
  int          n_fail        = 0;
  int          n_writes      = 0;
  int          quiet_cycles  = 0;
  logic [MAG_W-1:0] peak_magnitude = '0;

  function automatic int unsigned eff_count(int unsigned v, int unsigned most);
    if (v == 0) return 1;
    if (v > most) return most;
    return v;
  endfunction

  function automatic logic [MAG_W-1:0] floor_root(logic [SUM_W-1:0] v);
    logic [MAG_W-1:0] root;
    logic [MAG_W-1:0] trial;
    logic [RAD_W-1:0] sq;
    int b;
    root = '0;
    for (b = MAG_W - 1; b >= 0; b--) begin
      trial = root | (MAG_W'(1) << b);
      sq = RAD_W'(trial) * RAD_W'(trial);
      if (sq <= RAD_W'(v)) root = trial;
    end
    return root;
  endfunction

  function automatic void accumulate_sample(logic signed [SAMPLE_BITS-1:0] s);
    int unsigned      npix;
    int unsigned      ncoil;
    int unsigned      p;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SUM_W-1:0] total;
    pixel_result_t    r;
    bit               at_last_pixel;
    bit               at_last_coil;
    npix  = eff_count(pixel_reg, MAX_PIXELS);
    ncoil = eff_count(coil_reg, MAX_COILS);
    mag = s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
    p = pixel_at;
    if (p >= npix) p = npix - 1;
    at_last_pixel = (p + 1 >= npix);
    at_last_coil  = (coil_at + 1 >= ncoil);
    total = SUM_W'(mag) * SUM_W'(mag);
    if (coil_at != 0) total = total + pixel_sums[p];
    pixel_sums[p]    = total;
    pixel_written[p] = 1'b1;
    if (at_last_coil) begin
      r.magnitude  = floor_root(total);
      r.last_pixel = at_last_pixel;
      magnitudes_due = {magnitudes_due, r};
    end
    if (at_last_pixel) begin
      pixel_at = 0;
      coil_at  = at_last_coil ? 0 : coil_at + 1;
    end else begin
      pixel_at = p + 1;
    end
  endfunction

  function automatic bit span_written(int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) if (!pixel_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    if ($urandom_range(7, 0) != 0) return SAMPLE_BITS'($urandom);
    case ($urandom_range(5, 0))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      4:       return 16'sd1;
      default: return 16'sh8001;
    endcase
  endfunction

  function automatic void set_idling();
    case (n_queued * 3 / ITEMS_PLANNED)
      0: begin
        send_idle_pct = 33;
        recv_idle_pct = 63;
      end
      1: begin
        send_idle_pct = 63;
        recv_idle_pct = 33;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  function automatic void send(logic signed [SAMPLE_BITS-1:0] s);
    samples_pending = {samples_pending, s};
    n_queued++;
  endfunction

  // hold until every item is in and every magnitude out, then let the back end drain
  task automatic settle();
    do @(posedge clk_i); while (n_accepted != n_queued || magnitudes_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_counts(bit wr_pix, logic [CFG_W-1:0] pix,
                            bit wr_coil, logic [CFG_W-1:0] coil);
    if (wr_pix) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= REG_PIXEL_COUNT;
      cfg_wdata_i <= pix;
      @(posedge clk_i);
      pixel_reg = pix[PCNT_W-1:0];
      n_writes++;
    end
    if (wr_coil) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= REG_COIL_COUNT;
      cfg_wdata_i <= coil;
      @(posedge clk_i);
      coil_reg = coil[CCNT_W-1:0];
      n_writes++;
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int n, bit fixed, logic signed [SAMPLE_BITS-1:0] val);
    int i;
    set_idling();
    for (i = 0; i < n; i++) send(fixed ? val : random_sample());
    settle();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push     <= 1'b0;
      sample_i <= '0;
    end else begin
      if (push && !full) begin
        accumulate_sample(sample_i);
        n_accepted = n_accepted + 1;
      end
      if (!push || !full) begin
        if (samples_pending.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          push     <= 1'b1;
          sample_i <= samples_pending.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_checked = n_checked + 1;
        if (magnitude_o > peak_magnitude) peak_magnitude = magnitude_o;
        if (magnitudes_due.size() == 0) begin
          $error("magnitude %0d last_pixel %0b arrived with none due",
                 magnitude_o, last_pixel_o);
          n_fail = n_fail + 1;
        end else begin
          due = magnitudes_due.pop_front();
          if (magnitude_o !== due.magnitude) begin
            $error("magnitude: expected %0d, got %0d", due.magnitude, magnitude_o);
            n_fail = n_fail + 1;
          end
          if (last_pixel_o !== due.last_pixel) begin
            $error("last_pixel: expected %0b, got %0b", due.last_pixel, last_pixel_o);
            n_fail = n_fail + 1;
          end
        end
      end
      pop <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || cfg_we_i) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n_random;
    int n;
    int unsigned img;
    bit wr_pix;
    bit wr_coil;
    bit fixed;
    logic [CFG_W-1:0] new_pix;
    logic [CFG_W-1:0] new_coil;
    logic signed [SAMPLE_BITS-1:0] val;

    n_random = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset counts: one coil, full image, field extremes
    set_idling();
    send(16'sh0000);
    send(16'sd1);
    send(-16'sd1);
    send(16'sh7FFF);
    send(16'sh8000);
    send(16'sh5555);
    send(16'shAAAA);
    settle();

    // shrink the image under the current position: wrap on the next item
    set_counts(1'b1, 13'd3, 1'b0, '0);
    send(16'sd100);
    send(16'sh1234);
    send(-16'sd300);
    send(16'sh7FFE);
    settle();

    // zero counts act as one
    set_counts(1'b1, 13'd0, 1'b1, 13'd0);
    send(-16'sd12345);
    send(16'sd23456);
    settle();

    // three coils of two pixels, then stop partway into the next image
    set_counts(1'b1, 13'd2, 1'b1, 13'd3);
    repeat (9) send(random_sample());
    settle();

    // drop the coil count under the current coil: finish the image now
    set_counts(1'b0, '0, 1'b1, 13'd1);
    send(16'sh8000);
    settle();

    // pixel count past the store depth
    set_counts(1'b1, 13'd4097, 1'b0, '0);
    send(16'sh4000);
    send(-16'sd2);
    settle();

    // every coil at full negative scale on one pixel, coil count past the limit
    set_counts(1'b1, 13'd1, 1'b1, 13'h07F);
    run_phase(64, 1'b1, 16'sh8000);
    n_random = 64;

    while (n_random < RANDOM_ITEMS) begin
      case ($urandom_range(9, 0))
        0:       new_pix = 13'd0;
        1:       new_pix = 13'd1;
        2:       new_pix = 13'd2;
        3:       new_pix = 13'd4096;
        4:       new_pix = $urandom_range(1, 0) ? 13'd8191
                                                : CFG_W'($urandom_range(8190, 4097));
        default: new_pix = CFG_W'($urandom_range(40, 1));
      endcase
      case ($urandom_range(7, 0))
        0:       new_coil = 13'd0;
        1:       new_coil = 13'd1;
        2:       new_coil = 13'd64;
        3:       new_coil = CFG_W'($urandom_range(127, 65));
        4:       new_coil = CFG_W'($urandom_range(3, 2));
        default: new_coil = CFG_W'($urandom_range(12, 1));
      endcase
      if ($urandom_range(1, 0)) new_coil[CFG_W-1:CCNT_W] = (CFG_W - CCNT_W)'($urandom);
      wr_pix  = ($urandom_range(3, 0) != 0);
      wr_coil = ($urandom_range(3, 0) != 0);
      // keep reads on written entries when the image shrinks or grows mid-coil
      if (wr_pix && coil_at != 0 &&
          !span_written(eff_count(new_pix[PCNT_W-1:0], MAX_PIXELS)))
        wr_pix = 1'b0;
      set_counts(wr_pix, new_pix, wr_coil, new_coil);

      img = eff_count(pixel_reg, MAX_PIXELS) * eff_count(coil_reg, MAX_COILS);
      if (img <= 256) begin
        n = img * $urandom_range(2, 1);
        if ($urandom_range(3, 0) == 0) n = $urandom_range(img, 1);
      end else begin
        n = $urandom_range(150, 30);
      end
      fixed = ($urandom_range(9, 0) == 0);
      val = $urandom_range(1, 0) ? 16'sh8000 : 16'sh7FFF;
      run_phase(n, fixed, val);
      n_random += n;
    end

    $display("Run covered %0d samples and %0d magnitudes over %0d count writes,",
             n_accepted, n_checked, n_writes);
    $display("peak magnitude %0d, %0d mismatches.", peak_magnitude, n_fail);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
